/* rtl/crc8_framed_packet_receiver_defines.svh */
// Assertion macros used by the packet receiver RTL (cfpr_core).
// No dependencies; included by modules that carry assertions.
`ifndef CRC8_FRAMED_PACKET_RECEIVER_DEFINES_SVH
`define CRC8_FRAMED_PACKET_RECEIVER_DEFINES_SVH

// Checked on every rising clock edge, masked during reset.
`define CFPR_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define CFPR_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/cfpr_pkg.sv */
// Shared types and constants for the CRC-8 framed packet receiver.
// No dependencies.
package cfpr_pkg;

    localparam logic [7:0] SYNC_A   = 8'h3E;  // '>'
    localparam logic [7:0] SYNC_B   = 8'h2A;  // '*'
    localparam logic [7:0] CRC_POLY = 8'h8C;  // reflected Dallas/Maxim

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PAYLOAD = 2'd1,
        EV_GOOD    = 2'd2,
        EV_BAD     = 2'd3
    } event_t;

    typedef struct packed {
        logic        frame_ready;
        logic        error_flag;
        logic        in_progress;
        logic [15:0] payload_index;
        logic [7:0]  payload_byte;
        event_t      event_res;
    } result_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* rtl/crc8_framed_packet_receiver.sv */
// Byte stream deframer: sync '>' '*' '>', LE length, payload, CRC-8, trailer.
// Packet format and usage summary:
//   s_ channel carries one received byte per request (s_tdata).
//   m_ channel returns exactly one result per accepted byte: m_tuser is the
//   event (none, payload byte, frame good, frame bad), m_tdata the payload
//   byte, its index and the status flags.
//   cfg_we/cfg_wdata set the expected payload length; write only while idle.
//   A write clears the frame position, running CRC and frame-ready flag.
// Timing:
//   An accepted byte passes the input register, then the state update into
//   the result register. One byte per cycle is sustained while m_tready is
//   high; the loop through the CRC-8 byte step and the frame position compare
//   sets that rate.
// Reset (aresetn low, synchronous): hunting for sync, all state and flags
//   cleared, expected length zero, no result pending.
// Stall: with m_tready low the result register holds; one more byte is taken
//   into the input register, then s_tready drops until the result is taken.
// Depends on cfpr_pkg, cfpr_in_stage and cfpr_core.
module crc8_framed_packet_receiver
    import cfpr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] payload_byte, [23:8] payload_index,
                                   // [24] in_progress, [25] error_flag,
                                   // [26] frame_ready, [31:27] zero
    output logic [1:0]  m_tuser,   // [1:0] event_res
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata  // [15:0] expected_length
);

    logic       item_vld;
    logic [7:0] item_byte;
    logic       item_rdy;
    result_t    res;

    cfpr_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .item_vld  (item_vld),
        .item_byte (item_byte),
        .item_rdy  (item_rdy)
    );

    cfpr_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_vld  (item_vld),
        .item_byte (item_byte),
        .item_rdy  (item_rdy),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .res_vld   (m_tvalid),
        .res       (res),
        .res_rdy   (m_tready)
    );

    assign m_tuser = res.event_res;
    assign m_tdata = {5'd0, res.frame_ready, res.error_flag, res.in_progress,
                      res.payload_index, res.payload_byte};

endmodule

/* rtl/cfpr_in_stage.sv */
// Input register stage for received bytes.
// Depends on cfpr_pkg (none of its items used beyond the import convention).
module cfpr_in_stage
    import cfpr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic       item_vld,
    output logic [7:0] item_byte,
    input  logic       item_rdy
);

    logic       in_vld_reg;
    logic       in_vld_next;
    logic [7:0] in_byte_reg;

    assign s_tready    = !in_vld_reg || item_rdy;
    assign in_vld_next = s_tready ? s_tvalid : in_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    assign item_vld  = in_vld_reg;
    assign item_byte = in_byte_reg;

endmodule

/* rtl/cfpr_core.sv */
// Deframer state, CRC-8 check and result register.
// Depends on cfpr_pkg and crc8_framed_packet_receiver_defines.svh.
`include "crc8_framed_packet_receiver_defines.svh"

module cfpr_core
    import cfpr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        item_vld,
    input  logic [7:0]  item_byte,
    output logic        item_rdy,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output logic        res_vld,
    output result_t     res,
    input  logic        res_rdy
);

    typedef enum logic [3:0] {
        PH_HUNT  = 4'b0001,
        PH_STAR  = 4'b0010,
        PH_GT2   = 4'b0100,
        PH_FRAME = 4'b1000
    } phase_t;

    phase_t      phase_reg,    phase_next;
    logic [16:0] pos_reg,      pos_next;
    logic [15:0] len_reg,      len_next;
    logic [7:0]  crc_reg,      crc_next;
    logic [15:0] crc_seen_reg, crc_seen_next;
    logic        err_reg,      err_next;
    logic        rdy_reg,      rdy_next;
    logic [15:0] exp_len_reg;

    logic        out_vld_reg;
    result_t     out_res_reg;
    result_t     res_next;

    logic        advance;
    logic [16:0] n17;
    logic [16:0] lim_data;
    logic [16:0] lim_crc;
    logic [16:0] lim_busy;
    event_t      ev;
    logic [7:0]  pbyte;
    logic [15:0] pidx;

    assign item_rdy = !out_vld_reg || res_rdy;
    assign advance  = item_vld && item_rdy;

    assign n17      = {1'b0, exp_len_reg};
    assign lim_data = n17 + 17'd2;
    assign lim_crc  = n17 + 17'd4;
    assign lim_busy = n17 + 17'd6;

    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        crc_next      = crc_reg;
        crc_seen_next = crc_seen_reg;
        err_next      = err_reg;
        rdy_next      = rdy_reg;
        ev            = EV_NONE;
        pbyte         = 8'd0;
        pidx          = 16'd0;
        case (phase_reg)
            PH_HUNT: begin
                phase_next = (item_byte == SYNC_A) ? PH_STAR : PH_HUNT;
            end
            PH_STAR: begin
                phase_next = (item_byte == SYNC_B) ? PH_GT2 : PH_HUNT;
            end
            PH_GT2: begin
                phase_next = (item_byte == SYNC_A) ? PH_FRAME : PH_HUNT;
            end
            PH_FRAME: begin
                if (pos_reg == 17'd2 && len_reg != exp_len_reg) begin
                    // length mismatch: drop byte, back to hunting
                    phase_next = PH_HUNT;
                    pos_next   = 17'd0;
                    crc_next   = 8'd0;
                    err_next   = 1'b1;
                    ev         = EV_BAD;
                end else if (pos_reg < 17'd2) begin
                    if (pos_reg == 17'd0) begin
                        len_next = {len_reg[15:8], item_byte};
                    end else begin
                        len_next = {item_byte, len_reg[7:0]};
                    end
                    pos_next = pos_reg + 17'd1;
                end else if (pos_reg < lim_data) begin
                    crc_next = crc8_update(crc_reg, item_byte);
                    ev       = EV_PAYLOAD;
                    pbyte    = item_byte;
                    pidx     = pos_reg[15:0] - 16'd2;
                    pos_next = pos_reg + 17'd1;
                end else if (pos_reg < lim_crc) begin
                    if (pos_reg == lim_data) begin
                        crc_seen_next = {crc_seen_reg[15:8], item_byte};
                    end else begin
                        crc_seen_next = {item_byte, crc_seen_reg[7:0]};
                    end
                    pos_next = pos_reg + 17'd1;
                end else begin
                    // trailing byte: judge the frame
                    if (len_reg == exp_len_reg && crc_seen_reg == {8'd0, crc_reg}) begin
                        err_next = 1'b0;
                        rdy_next = 1'b1;
                        ev       = EV_GOOD;
                    end else begin
                        err_next = 1'b1;
                        ev       = EV_BAD;
                    end
                    phase_next = PH_HUNT;
                    pos_next   = 17'd0;
                    crc_next   = 8'd0;
                end
            end
            default: begin
                phase_next = PH_HUNT;
                pos_next   = 17'd0;
                crc_next   = 8'd0;
            end
        endcase
        res_next.event_res     = ev;
        res_next.payload_byte  = pbyte;
        res_next.payload_index = pidx;
        res_next.in_progress   = (phase_next != PH_HUNT) ||
                                 (pos_next != 17'd0 && pos_next < lim_busy);
        res_next.error_flag    = err_next;
        res_next.frame_ready   = rdy_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HUNT;
            pos_reg      <= 17'd0;
            len_reg      <= 16'd0;
            crc_reg      <= 8'd0;
            crc_seen_reg <= 16'd0;
            err_reg      <= 1'b0;
            rdy_reg      <= 1'b0;
            exp_len_reg  <= 16'd0;
        end else if (cfg_we) begin
            exp_len_reg <= cfg_wdata;
            pos_reg     <= 17'd0;
            crc_reg     <= 8'd0;
            rdy_reg     <= 1'b0;
        end else if (advance) begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            crc_reg      <= crc_next;
            crc_seen_reg <= crc_seen_next;
            err_reg      <= err_next;
            rdy_reg      <= rdy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (res_rdy) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign res_vld = out_vld_reg;
    assign res     = out_res_reg;

    `CFPR_ASSERT(a_pos_only_in_frame, aclk, aresetn, (pos_reg != 17'd0) |-> (phase_reg == PH_FRAME), "frame position moved outside a frame")
    `CFPR_ASSERT(a_cfg_clears, aclk, aresetn, cfg_we |=> (pos_reg == 17'd0 && crc_reg == 8'd0 && !rdy_reg), "length write did not clear frame state")
    `CFPR_ASSERT(a_good_flags, aclk, aresetn, (out_vld_reg && out_res_reg.event_res == EV_GOOD) |-> (out_res_reg.frame_ready && !out_res_reg.error_flag), "good frame without ready flag")
    `CFPR_ASSERT(a_bad_flags, aclk, aresetn, (out_vld_reg && out_res_reg.event_res == EV_BAD) |-> out_res_reg.error_flag, "bad frame without error flag")
    `CFPR_ASSERT(a_payload_busy, aclk, aresetn, (out_vld_reg && out_res_reg.event_res == EV_PAYLOAD) |-> out_res_reg.in_progress, "payload byte reported while idle")

endmodule

/* tb/crc8_framed_packet_receiver_tb.sv */
// Testbench for crc8_framed_packet_receiver: drives framed byte streams and checks
// every result against a cycle-free model of the deframer held in a scoreboard class.
// Depends on cfpr_pkg and the receiver RTL.
`timescale 1ns / 100ps

module crc8_framed_packet_receiver_tb;
    import cfpr_pkg::*;

    typedef enum logic [1:0] {
        WAIT_SYNC_A  = 2'd0,
        WAIT_SYNC_B  = 2'd1,
        WAIT_SYNC_A2 = 2'd2,
        IN_FRAME     = 2'd3
    } sync_state_t;

    typedef enum logic [2:0] {
        FR_GOOD,
        FR_BAD_CRC,
        FR_CRC_HIGH,
        FR_BAD_LEN,
        FR_BROKEN_SYNC,
        FR_NOISE
    } frame_kind_t;

    typedef struct packed {
        event_t      ev;
        logic [7:0]  pbyte;
        logic [15:0] pidx;
        logic        busy;
        logic        err;
        logic        rdy;
    } rx_result_t;

    class rx_scoreboard;
        logic [15:0]  exp_len;
        sync_state_t  sync_state;
        logic [16:0]  fpos;
        logic [15:0]  len_seen;
        logic [7:0]   crc_acc;
        logic [15:0]  crc_seen;
        logic         err_sticky;
        logic         rdy_sticky;
        rx_result_t   deframe_results_q[$];
        int           mismatches;
        int           checked;

        function new();
            exp_len    = '0;
            sync_state = WAIT_SYNC_A;
            fpos       = '0;
            len_seen   = '0;
            crc_acc    = '0;
            crc_seen   = '0;
            err_sticky = 1'b0;
            rdy_sticky = 1'b0;
            mismatches = 0;
            checked    = 0;
        endfunction

        // Dallas/Maxim CRC-8, reflected, one data bit at a time
        static function logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] d);
            logic [7:0] r;
            logic       fb;
            r = c;
            for (int i = 0; i < 8; i++) begin
                fb = r[0] ^ d[i];
                r  = r >> 1;
                if (fb) r = r ^ CRC_POLY;
            end
            return r;
        endfunction

        function int pending();
            return deframe_results_q.size();
        endfunction

        function void write_length(input logic [15:0] v);
            exp_len    = v;
            fpos       = '0;
            crc_acc    = '0;
            rdy_sticky = 1'b0;
        endfunction

        function void rehunt();
            sync_state = WAIT_SYNC_A;
            fpos       = '0;
            crc_acc    = '0;
        endfunction

        function void note_byte(input logic [7:0] b);
            rx_result_t r;
            int         n;
            int         fp;
            n       = int'(exp_len);
            fp      = int'(fpos);
            r.ev    = EV_NONE;
            r.pbyte = '0;
            r.pidx  = '0;
            if (sync_state == WAIT_SYNC_A) begin
                sync_state = (b == SYNC_A) ? WAIT_SYNC_B : WAIT_SYNC_A;
            end else if (sync_state == WAIT_SYNC_B) begin
                sync_state = (b == SYNC_B) ? WAIT_SYNC_A2 : WAIT_SYNC_A;
            end else if (sync_state == WAIT_SYNC_A2) begin
                sync_state = (b == SYNC_A) ? IN_FRAME : WAIT_SYNC_A;
            end else if (fp == 2 && len_seen != exp_len) begin
                // wrong length: byte dropped, back to hunting
                rehunt();
                err_sticky = 1'b1;
                r.ev = EV_BAD;
            end else if (fp < 2) begin
                if (fp == 0) len_seen[7:0] = b;
                else         len_seen[15:8] = b;
                fpos = fpos + 17'd1;
            end else if (fp < n + 2) begin
                crc_acc = crc_step(crc_acc, b);
                r.ev    = EV_PAYLOAD;
                r.pbyte = b;
                r.pidx  = 16'(fp - 2);
                fpos    = fpos + 17'd1;
            end else if (fp < n + 4) begin
                if (fp == n + 2) crc_seen[7:0] = b;
                else             crc_seen[15:8] = b;
                fpos = fpos + 17'd1;
            end else begin
                // trailing byte: judge the frame
                if (len_seen == exp_len && crc_seen == {8'h00, crc_acc}) begin
                    err_sticky = 1'b0;
                    rdy_sticky = 1'b1;
                    r.ev = EV_GOOD;
                end else begin
                    err_sticky = 1'b1;
                    r.ev = EV_BAD;
                end
                rehunt();
            end
            r.busy = (sync_state != WAIT_SYNC_A) || (fpos != 0 && int'(fpos) < n + 6);
            r.err  = err_sticky;
            r.rdy  = rdy_sticky;
            deframe_results_q.push_back(r);
        endfunction

        function void check_result(input logic [31:0] td, input logic [1:0] tu);
            rx_result_t e;
            if (deframe_results_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: tdata=%08h tuser=%0d", td, tu);
                return;
            end
            e = deframe_results_q.pop_front();
            checked++;
            if (tu !== e.ev || td[7:0] !== e.pbyte || td[23:8] !== e.pidx ||
                td[24] !== e.busy || td[25] !== e.err || td[26] !== e.rdy ||
                td[31:27] !== 5'd0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d exp: ev=%0d byte=%02h idx=%0d busy=%0b err=%0b rdy=%0b",
                             checked, e.ev, e.pbyte, e.pidx, e.busy, e.err, e.rdy);
                    $display("  got: ev=%0d byte=%02h idx=%0d busy=%0b err=%0b rdy=%0b pad=%0h",
                             tu, td[7:0], td[23:8], td[24], td[25], td[26], td[31:27]);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;

    rx_scoreboard sb;
    logic [15:0]  cur_len    = 16'h0000;
    bit           idle_en    = 1'b1;
    int           sent_count = 0;
    int           stall_left = 0;

    crc8_framed_packet_receiver dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(8 * 1000000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 13);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // check before noting, so a stray result never pairs with a fresh request
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
            if (s_tvalid && s_tready) sb.note_byte(s_tdata);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_expected_length(input logic [15:0] v);
        wait_drained();
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        sb.write_length(v);
        cfg_we  <= 1'b0;
        cur_len = v;
    endtask

    task automatic send_frame(input frame_kind_t kind);
        logic [7:0]  crc;
        logic [7:0]  b;
        logic [7:0]  want;
        logic [15:0] lf;
        logic [15:0] crc_word;
        int          nb;
        case (kind)
            FR_NOISE: begin
                nb = $urandom_range(1, 6);
                repeat (nb) send_byte(8'($urandom_range(0, 255)));
            end
            FR_BROKEN_SYNC: begin
                nb = $urandom_range(1, 2);
                send_byte(SYNC_A);
                if (nb == 2) send_byte(SYNC_B);
                want = (nb == 1) ? SYNC_B : SYNC_A;
                do b = 8'($urandom_range(0, 255)); while (b == want);
                send_byte(b);
            end
            default: begin
                send_byte(SYNC_A);
                send_byte(SYNC_B);
                send_byte(SYNC_A);
                lf = cur_len;
                if (kind == FR_BAD_LEN) lf = cur_len ^ 16'($urandom_range(1, 65535));
                send_byte(lf[7:0]);
                send_byte(lf[15:8]);
                if (kind == FR_BAD_LEN) begin
                    send_byte(8'($urandom_range(0, 255)));
                end else begin
                    crc = 8'h00;
                    repeat (cur_len) begin
                        b   = 8'($urandom_range(0, 255));
                        crc = rx_scoreboard::crc_step(crc, b);
                        send_byte(b);
                    end
                    crc_word = {8'h00, crc};
                    if (kind == FR_BAD_CRC)
                        crc_word[7:0] = crc ^ 8'($urandom_range(1, 255));
                    if (kind == FR_CRC_HIGH)
                        crc_word[15:8] = 8'($urandom_range(1, 255));
                    send_byte(crc_word[7:0]);
                    send_byte(crc_word[15:8]);
                    send_byte(8'($urandom_range(0, 255)));
                end
            end
        endcase
    endtask

    initial begin
        int          rand_start;
        int          nfr;
        int          pick;
        bit          big;
        frame_kind_t k;

        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty payload, broken sync, length extremes, write mid-frame
        write_expected_length(16'h0000);
        send_frame(FR_GOOD);
        send_byte(SYNC_A);
        send_byte(SYNC_A);
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(8'h00);
        write_expected_length(16'hFFFF);
        send_frame(FR_BAD_LEN);
        write_expected_length(16'h0001);
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(SYNC_A);
        send_byte(8'h07);
        // sync is kept across the write, frame restarts at the length bytes
        write_expected_length(16'h0001);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(rx_scoreboard::crc_step(8'h00, 8'hFF));
        send_byte(8'h00);
        send_byte(8'hFF);

        // random phases, mostly well-formed frames at small lengths
        rand_start = sent_count;
        while (sent_count - rand_start < 500) begin
            big = ($urandom_range(0, 4) == 0);
            write_expected_length(big ? 16'($urandom_range(0, 65535))
                                      : 16'($urandom_range(0, 12)));
            idle_en = ($urandom_range(0, 3) != 0);
            nfr = $urandom_range(3, 10);
            repeat (nfr) begin
                pick = $urandom_range(0, 99);
                if (big) begin
                    k = (pick < 50) ? FR_BAD_LEN : (pick < 80) ? FR_BROKEN_SYNC : FR_NOISE;
                end else begin
                    k = (pick < 50) ? FR_GOOD :
                        (pick < 62) ? FR_BAD_CRC :
                        (pick < 70) ? FR_CRC_HIGH :
                        (pick < 80) ? FR_BAD_LEN :
                        (pick < 90) ? FR_BROKEN_SYNC : FR_NOISE;
                end
                send_frame(k);
            end
        end

        // last part: back-to-back good frames, no idling
        idle_en = 1'b0;
        write_expected_length(16'd12);
        repeat (3) send_frame(FR_GOOD);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
